### rtl/core/shell_exchange_sort_unit_assert.svh
// assertion macros shared by the shell exchange sort rtl
`ifndef SHELL_EXCHANGE_SORT_UNIT_ASSERT_SVH
`define SHELL_EXCHANGE_SORT_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SESU_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sesu check failed");

// next-cycle implication, checked out of reset
`define SESU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sesu check failed");

`endif

### rtl/core/sesu_pkg.sv
// shared types, constants and key compare helper for the shell exchange sort
package sesu_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int TAG_W     = 10;

    // one stored record, key in the low bits
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } rec_t;

    // status from the sort engine to the top level
    typedef struct packed {
        logic busy;
        logic done;
    } sort_sts_t;

    // zero every byte after the first nul byte
    function automatic logic [KEY_W-1:0] string_view(input logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] r;
        begin
            if (k[31:24] == 8'h00)
                r = '0;
            else if (k[23:16] == 8'h00)
                r = {k[31:24], 24'h000000};
            else if (k[15:8] == 8'h00)
                r = {k[31:16], 16'h0000};
            else if (k[7:0] == 8'h00)
                r = {k[31:8], 8'h00};
            else
                r = k;
            return r;
        end
    endfunction

endpackage

### rtl/core/sesu_store.sv
// record memory: one write port, two registered read ports
module sesu_store #(
    parameter int DEPTH  = sesu_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  sesu_pkg::rec_t     wdata,
    input  logic [ADDR_W-1:0]  raddr_a,
    input  logic [ADDR_W-1:0]  raddr_b,
    output sesu_pkg::rec_t     rdata_a,
    output sesu_pkg::rec_t     rdata_b
);

    sesu_pkg::rec_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/core/sesu_sort.sv
// gap-halving exchange sort engine working on the record memory
`include "shell_exchange_sort_unit_assert.svh"

module sesu_sort #(
    parameter int DEPTH  = sesu_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CNT_W-1:0]     count,
    input  sesu_pkg::rec_t       rdata_a,
    input  sesu_pkg::rec_t       rdata_b,
    output logic [ADDR_W-1:0]    raddr_a,
    output logic [ADDR_W-1:0]    raddr_b,
    output logic                 we,
    output logic [ADDR_W-1:0]    waddr,
    output sesu_pkg::rec_t       wdata,
    output sesu_pkg::sort_sts_t  sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_RD,
        ST_CMP,
        ST_WR2
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   gap_reg, gap_next;
    logic [ADDR_W-1:0]  i_reg, i_next;
    logic               swapped_reg, swapped_next;
    logic               done_reg, done_next;
    sesu_pkg::rec_t     hold_reg;

    logic [ADDR_W-1:0]  j_idx;
    logic [CNT_W-1:0]   gap_half;
    logic               pass_end;
    logic               greater;

    // partner index and end-of-pass test
    assign j_idx    = i_reg + gap_reg[ADDR_W-1:0];
    assign gap_half = gap_reg >> 1;
    assign pass_end = (CNT_W'(i_reg) + gap_reg + CNT_W'(1)) >= n_reg;
    assign greater  = sesu_pkg::string_view(rdata_a.key) >
                      sesu_pkg::string_view(rdata_b.key);

    // memory port drive
    assign raddr_a = i_reg;
    assign raddr_b = j_idx;
    assign we      = ((state_reg == ST_CMP) && greater) || (state_reg == ST_WR2);
    assign waddr   = (state_reg == ST_WR2) ? j_idx : i_reg;
    assign wdata   = (state_reg == ST_WR2) ? hold_reg : rdata_b;

    assign sts.busy = (state_reg != ST_IDLE);
    assign sts.done = done_reg;

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        gap_next     = gap_reg;
        i_next       = i_reg;
        swapped_next = swapped_reg;
        done_next    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = count;
                    gap_next   = count;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (gap_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // a zero gap round changes nothing
                    gap_next     = gap_half;
                    i_next       = '0;
                    swapped_next = 1'b0;
                    state_next   = (gap_half == '0) ? ST_ROUND : ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (greater)
                begin
                    swapped_next = 1'b1;
                    state_next   = ST_WR2;
                end
                else if (!pass_end)
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_RD;
                end
                else if (swapped_reg)
                begin
                    i_next       = '0;
                    swapped_next = 1'b0;
                    state_next   = ST_RD;
                end
                else
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_WR2:
            begin
                if (!pass_end)
                begin
                    i_next     = i_reg + ADDR_W'(1);
                    state_next = ST_RD;
                end
                else
                begin
                    // pass had a swap, run it again
                    i_next       = '0;
                    swapped_next = 1'b0;
                    state_next   = ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            gap_reg     <= '0;
            i_reg       <= '0;
            swapped_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            gap_reg     <= gap_next;
            i_reg       <= i_next;
            swapped_reg <= swapped_next;
            done_reg    <= done_next;
        end
    end

    // left record held for the second swap write
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            hold_reg <= rdata_a;
        end
    end

    // second swap write always follows a compare that swapped
    `SESU_ASSERT_NOW(a_wr2_after_cmp, clk, rst_n, state_reg == ST_WR2, $past(state_reg) == ST_CMP)
    // partner read stays inside the loaded set
    `SESU_ASSERT_NOW(a_partner_in_set, clk, rst_n, state_reg == ST_RD, CNT_W'(j_idx) < n_reg)
    // finishing only happens out of a round with the gap used up
    `SESU_ASSERT_NXT(a_done_gap_zero, clk, rst_n, state_reg == ST_ROUND && gap_reg != '0, !done_reg)

endmodule

### rtl/core/shell_exchange_sort_unit.sv
// top level: record loading, sort control and sorted output stream
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid/s_tready         s_tdata key,tag  s_tlast closes set
// m_*      out  m_tvalid/m_tready         m_tdata key,tag  m_tlast  m_tuser overflow
//
// loading takes one beat per cycle; records past DEPTH are dropped and flagged
// sorting: a compare reads the pair (RD, CMP); a swap needs a second write (WR2)
//   (one memory write port); passes repeat per gap round until a pass makes no swap
// output: memory read, load and handshake per beat, one at a time, plus sink stall
// no input beat is taken from the closing beat until the last result leaves
// reset is asynchronous active low; the record memory needs no clearing
`include "shell_exchange_sort_unit_assert.svh"

module shell_exchange_sort_unit #(
    parameter int DEPTH = sesu_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // [31:0] sort_key, [41:32] record_tag, zero pad
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,   // [31:0] out_key, [41:32] out_tag, zero pad
    output logic         m_tlast,
    output logic         m_tuser    // [0] overflowed
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 ovf_reg, ovf_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 start_reg, start_next;
    logic                 valid_reg, valid_next;
    logic                 last_reg, last_next;
    logic                 user_reg, user_next;
    sesu_pkg::rec_t       out_rec_reg;

    logic                 in_beat;
    logic                 out_beat;
    logic                 room;
    sesu_pkg::rec_t       in_rec;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    sesu_pkg::rec_t       mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr_a;
    sesu_pkg::rec_t       rdata_a;
    sesu_pkg::rec_t       rdata_b;

    logic                 srt_we;
    logic [ADDR_W-1:0]    srt_waddr;
    sesu_pkg::rec_t       srt_wdata;
    logic [ADDR_W-1:0]    srt_raddr_a;
    logic [ADDR_W-1:0]    srt_raddr_b;
    sesu_pkg::sort_sts_t  sort_sts;

    // handshakes
    assign s_tready = (state_reg == ST_LOAD);
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = valid_reg && m_tready;
    assign room     = count_reg < CNT_W'(DEPTH);

    assign in_rec.key = s_tdata[31:0];
    assign in_rec.tag = s_tdata[41:32];

    // memory port sharing between load, sort and output phases
    assign mem_we      = (in_beat && room) || srt_we;
    assign mem_waddr   = (state_reg == ST_SORT) ? srt_waddr : count_reg[ADDR_W-1:0];
    assign mem_wdata   = (state_reg == ST_SORT) ? srt_wdata : in_rec;
    assign mem_raddr_a = (state_reg == ST_SORT) ? srt_raddr_a : idx_reg[ADDR_W-1:0];

    sesu_store #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W)
    ) u_store (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (srt_raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    sesu_sort #(
        .DEPTH   (DEPTH),
        .ADDR_W  (ADDR_W),
        .CNT_W   (CNT_W)
    ) u_sort (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .count   (count_reg),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .raddr_a (srt_raddr_a),
        .raddr_b (srt_raddr_b),
        .we      (srt_we),
        .waddr   (srt_waddr),
        .wdata   (srt_wdata),
        .sts     (sort_sts)
    );

    // output beat
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, out_rec_reg.tag, out_rec_reg.key};
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    // control next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        start_next = 1'b0;
        valid_next = valid_reg;
        last_next  = last_reg;
        user_next  = user_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (room)
                        count_next = count_reg + CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                    if (s_tlast)
                    begin
                        start_next = 1'b1;
                        state_next = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                if (sort_sts.done)
                begin
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                valid_next = 1'b1;
                last_next  = (idx_reg + CNT_W'(1)) == count_reg;
                user_next  = ovf_reg;
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                if (out_beat)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            start_reg <= 1'b0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            user_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            start_reg <= start_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
            user_reg  <= user_next;
        end
    end

    // output record payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT_LD)
        begin
            out_rec_reg <= rdata_a;
        end
    end

    // stored record count never passes capacity
    `SESU_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    // sort engine is quiet while records load
    `SESU_ASSERT_NOW(a_idle_on_load, clk, rst_n, state_reg == ST_LOAD, !sort_sts.busy)
    // sort completion moves straight into output
    `SESU_ASSERT_NXT(a_done_to_emit, clk, rst_n, sort_sts.done, state_reg == ST_EMIT_RD)

endmodule

### sim/tb_shell_exchange_sort_unit.sv
// self-checking testbench for the shell exchange sort unit
module tb_shell_exchange_sort_unit;

    localparam int DEPTH       = sesu_pkg::DEPTH_DEF;
    localparam int KW          = sesu_pkg::KEY_W;
    localparam int TW          = sesu_pkg::TAG_W;
    localparam int RANDOM_RECS = 155;
    localparam int DRAIN_WAIT  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DIR_ROWS    = 21;

    // one stimulus row: record in, plus the sorted beat where it is obvious
    typedef struct packed {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic          last;
        logic          typed;
        logic [KW-1:0] want_key;
        logic [TW-1:0] want_tag;
    } dir_row_t;

    // one sorted output beat
    typedef struct packed {
        logic [KW-1:0] key;
        logic [TW-1:0] tag;
        logic          last;
        logic          ovf;
    } sorted_beat_t;

    // directed records: single-record sets, nul masking, ties, reversed pair, bit patterns
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{32'hFFFFFFFF, 10'd1023, 1'b1, 1'b1, 32'hFFFFFFFF, 10'd1023},
        '{32'h00000000, 10'd0,    1'b1, 1'b1, 32'h00000000, 10'd0},
        '{32'h00FFFFFF, 10'd5,    1'b1, 1'b1, 32'h00FFFFFF, 10'd5},
        '{32'h41005A5A, 10'd10,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h41000000, 10'd11,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h7A7A7A7A, 10'd12,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h00ABCDEF, 10'd13,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h41420043, 10'd14,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h80000001, 10'd15,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h414243FF, 10'd16,   1'b1, 1'b0, 32'h0, 10'd0},
        '{32'h55555555, 10'd20,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h55555555, 10'd21,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h55555555, 10'd22,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h55555555, 10'd23,   1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h30303030, 10'd24,   1'b1, 1'b0, 32'h0, 10'd0},
        '{32'hFFFFFFFE, 10'd1,    1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h01010101, 10'd2,    1'b1, 1'b0, 32'h0, 10'd0},
        '{32'hAAAAAAAA, 10'h2AA,  1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h55555555, 10'h155,  1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h12345678, 10'h3FF,  1'b0, 1'b0, 32'h0, 10'd0},
        '{32'h00000001, 10'h200,  1'b1, 1'b0, 32'h0, 10'd0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // shadow copy of the record store
    logic [KW-1:0] held_key [DEPTH];
    logic [TW-1:0] held_tag [DEPTH];
    int            held_count = 0;
    bit            held_ovf   = 1'b0;

    sorted_beat_t  sorted_due [$];

    int unsigned   mismatches    = 0;
    int unsigned   records_in    = 0;
    int unsigned   beats_out     = 0;
    int unsigned   sets_closed   = 0;
    int unsigned   overflow_sets = 0;
    int unsigned   cycle_count   = 0;
    int            burst_left    = 0;

    shell_exchange_sort_unit #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #6 clk = ~clk;

    // key as a nul-terminated string: bytes after the first nul count as zero
    function automatic logic [KW-1:0] visible_key(input logic [KW-1:0] k);
        logic [KW-1:0] v;
        bit            ended;
        v     = k;
        ended = 1'b0;
        for (int b = 3; b >= 0; b--)
        begin
            if (ended)
                v[b*8 +: 8] = 8'h00;
            else if (k[b*8 +: 8] == 8'h00)
                ended = 1'b1;
        end
        return v;
    endfunction

    // gap-halving exchange sort over the first n held records
    task automatic order_held(input int n);
        int            gap;
        bit            moved;
        logic [KW-1:0] tk;
        logic [TW-1:0] tt;
        gap = n;
        while (gap >= 1)
        begin
            gap = gap / 2;
            do
            begin
                moved = 1'b0;
                for (int i = 0; i + gap < n; i++)
                begin
                    if (visible_key(held_key[i]) > visible_key(held_key[i+gap]))
                    begin
                        tk                = held_key[i];
                        tt                = held_tag[i];
                        held_key[i]       = held_key[i+gap];
                        held_tag[i]       = held_tag[i+gap];
                        held_key[i+gap]   = tk;
                        held_tag[i+gap]   = tt;
                        moved             = 1'b1;
                    end
                end
            end
            while (moved);
        end
    endtask

    // take one accepted record; on the closing record sort the set, queue it if publish
    task automatic absorb_record(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                                 input bit last, input bit publish);
        sorted_beat_t sb;
        if (held_count < DEPTH)
        begin
            held_key[held_count] = key;
            held_tag[held_count] = tag;
            held_count++;
        end
        else
            held_ovf = 1'b1;
        records_in++;
        if (last)
        begin
            order_held(held_count);
            if (publish)
            begin
                for (int k = 0; k < held_count; k++)
                begin
                    sb.key  = held_key[k];
                    sb.tag  = held_tag[k];
                    sb.last = (k + 1 == held_count);
                    sb.ovf  = held_ovf;
                    sorted_due.push_back(sb);
                end
            end
            if (held_ovf)
                overflow_sets++;
            sets_closed++;
            held_count = 0;
            held_ovf   = 1'b0;
        end
    endtask

    // random key: raw bits, small alphabet, short strings with junk after nul, repeats, shared prefixes
    function automatic logic [KW-1:0] pick_key(input logic [KW-1:0] prev);
        logic [KW-1:0] k;
        int            len;
        k = $urandom;
        case ($urandom_range(0, 4))
            0: ;
            1:
            begin
                for (int b = 0; b < 4; b++)
                    k[b*8 +: 8] = 8'(8'h41 + $urandom_range(0, 3));
            end
            2:
            begin
                len = $urandom_range(0, 3);
                k[(3-len)*8 +: 8] = 8'h00;
                for (int b = 4 - len; b < 4; b++)
                    k[b*8 +: 8] = 8'($urandom_range(1, 255));
            end
            3: k = prev;
            default:
            begin
                k[31:24] = 8'(8'h41 + $urandom_range(0, 2));
                k[23:16] = 8'(8'h41 + $urandom_range(0, 2));
            end
        endcase
        return k;
    endfunction

    // offer one record in bursts with random gaps, then predict on acceptance
    task automatic offer_record(input logic [KW-1:0] key, input logic [TW-1:0] tag,
                                input bit last, input bit typed,
                                input logic [KW-1:0] want_key, input logic [TW-1:0] want_tag);
        int           gap;
        sorted_beat_t sb;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(30, 60);
            end
            else
            begin
                gap        = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 10);
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, tag, key};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_record(key, tag, last, !typed);
        if (typed)
        begin
            sb.key  = want_key;
            sb.tag  = want_tag;
            sb.last = 1'b1;
            sb.ovf  = 1'b0;
            sorted_due.push_back(sb);
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [KW-1:0] want,
                                 input logic [KW-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endtask

    // sink: own ready pattern, with one long hold-off once output is flowing
    initial
    begin : sink_pattern
        int unsigned tick;
        int unsigned hold_left;
        bit          held_once;
        tick      = 0;
        hold_left = 0;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            tick++;
            if (!held_once && beats_out >= 40 && m_tvalid)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((tick / 250) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= (tick % 4) != 3;
                    2:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (tick % 5) == 0;
                endcase
            end
        end
    end

    // compare each sorted beat with the oldest expectation
    always @(posedge clk)
    begin : beat_check
        sorted_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_out++;
            if (sorted_due.size() == 0)
                flag_mismatch("unexpected beat key", '0, m_tdata[31:0]);
            else
            begin
                want = sorted_due.pop_front();
                if (m_tdata[31:0] !== want.key)
                    flag_mismatch("key", want.key, m_tdata[31:0]);
                if (m_tdata[41:32] !== want.tag)
                    flag_mismatch("tag", KW'(want.tag), KW'(m_tdata[41:32]));
                if (m_tlast !== want.last)
                    flag_mismatch("last", KW'(want.last), KW'(m_tlast));
                if (m_tuser !== want.ovf)
                    flag_mismatch("overflow flag", KW'(want.ovf), KW'(m_tuser));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d beats still expected", sorted_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // reset, directed table, random sets, drain and verdict
    initial
    begin : stimulus
        int            sent;
        int            set_no;
        int            n;
        logic [KW-1:0] prev;
        logic [KW-1:0] key;
        dir_row_t      row;
        sent   = 0;
        set_no = 0;
        prev   = 32'h41424344;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = DIR_TABLE[r];
            offer_record(row.key, row.tag, row.last, row.typed, row.want_key, row.want_tag);
        end

        // mostly small sets; one exactly full set and one whose tail is dropped
        while (sent < RANDOM_RECS || set_no < 6)
        begin
            if (set_no == 2)
                n = DEPTH;
            else if (set_no == 5)
                n = DEPTH + 2;
            else if ($urandom_range(0, 4) == 0)
                n = $urandom_range(10, 20);
            else
                n = $urandom_range(1, 9);
            for (int k = 0; k < n; k++)
            begin
                key = pick_key(prev);
                prev = key;
                offer_record(key, TW'($urandom_range(0, 1023)), k == n - 1, 1'b0, '0, '0);
            end
            sent += n;
            set_no++;
        end
        s_tvalid <= 1'b0;

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sorted %0d sets from %0d records (%0d with dropped records), %0d beats out",
                 sets_closed, records_in, overflow_sets, beats_out);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/sesu_pkg.sv
rtl/core/sesu_store.sv
rtl/core/sesu_sort.sv
rtl/core/shell_exchange_sort_unit.sv
sim/tb_shell_exchange_sort_unit.sv
